// ----- rtl/core/jfb64e_pkg.sv -----
// ----------------------------------------------------------------------------
// jfb64e_pkg
// Types, constants and the base64 alphabet for the framed base64 encoder.
// ----------------------------------------------------------------------------
package jfb64e_pkg;

  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned MAX_CHARS = 4;

  localparam logic [6:0] PAD_CODE = 7'd61;
  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_EOI = 8'hD9;

  // Leftover bit counts that the encoder can hold.
  localparam logic [2:0] LEFT_NONE = 3'd0;
  localparam logic [2:0] LEFT_TWO  = 3'd2;
  localparam logic [2:0] LEFT_FOUR = 3'd4;

  typedef struct packed {
    logic [3:0] leftover_bits;
    logic [2:0] leftover_count;
    logic [1:0] chars_mod_four;
    logic       previous_was_ff;
  } enc_state_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] codes;
    logic [2:0]                       count;
    logic                             frame_end;
  } burst_t;

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd97 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      r = 7'd48 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      r = 7'd43;
    end else begin
      r = 7'd47;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/jpeg_frame_base64_encoder_top.sv -----
// ----------------------------------------------------------------------------
// jpeg_frame_base64_encoder_top
// Path: a byte accepted into the input register is expanded combinationally
// and, once the output stage can take it, loaded there as a burst of characters.
// Throughput: one character per cycle while out_ready is high; a byte yields
// one to four characters, sent one at a time by the single output character port.
// Reset clears the encoder state, the input register and the output burst.
// ----------------------------------------------------------------------------
module jpeg_frame_base64_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  output logic       frame_end,
  output logic       item_last
);

  logic [7:0]             byte_q;
  logic                   byte_valid;
  logic                   can_load;
  logic                   load;
  jfb64e_pkg::enc_state_t state;
  jfb64e_pkg::enc_state_t state_next;
  jfb64e_pkg::burst_t     burst;

  assign load     = byte_valid && can_load;
  assign in_ready = !byte_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

  jfb64e_expand u_expand (
    .data_byte (byte_q),
    .cur       (state),
    .nxt       (state_next),
    .burst     (burst)
  );

  jfb64e_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .frame_end (frame_end),
    .item_last (item_last)
  );

endmodule

// ----- rtl/core/jfb64e_expand.sv -----
// ----------------------------------------------------------------------------
// jfb64e_expand
// Turns one byte and the encoder state into a burst of up to four characters
// and the next encoder state.
// ----------------------------------------------------------------------------
module jfb64e_expand (
  input  logic [7:0]           data_byte,
  input  jfb64e_pkg::enc_state_t cur,
  output jfb64e_pkg::enc_state_t nxt,
  output jfb64e_pkg::burst_t     burst
);

  logic [5:0] sx0;
  logic [5:0] sx1;
  logic [5:0] flush_sx;
  logic [3:0] lo_bits;
  logic [2:0] lo_count;
  logic [2:0] n_data;
  logic [2:0] n_all;
  logic [1:0] mod_after;
  logic [2:0] pads;
  logic [2:0] total;
  logic       frame_done;
  logic       flush;
  logic [6:0] dchar [3];

  always_comb begin
    sx0      = data_byte[7:2];
    sx1      = 6'd0;
    lo_bits  = {2'b00, data_byte[1:0]};
    lo_count = jfb64e_pkg::LEFT_TWO;
    n_data   = 3'd1;
    case (cur.leftover_count)
      jfb64e_pkg::LEFT_TWO: begin
        sx0      = {cur.leftover_bits[1:0], data_byte[7:4]};
        lo_bits  = data_byte[3:0];
        lo_count = jfb64e_pkg::LEFT_FOUR;
      end
      jfb64e_pkg::LEFT_FOUR: begin
        sx0      = {cur.leftover_bits, data_byte[7:6]};
        sx1      = data_byte[5:0];
        lo_bits  = 4'd0;
        lo_count = jfb64e_pkg::LEFT_NONE;
        n_data   = 3'd2;
      end
      default: begin
      end
    endcase

    if (lo_count == jfb64e_pkg::LEFT_FOUR) begin
      flush_sx = {lo_bits, 2'b00};
    end else begin
      flush_sx = {lo_bits[1:0], 4'b0000};
    end

    frame_done = cur.previous_was_ff && (data_byte == jfb64e_pkg::MARK_EOI);
    flush      = frame_done && (lo_count != jfb64e_pkg::LEFT_NONE);
    n_all      = n_data + {2'b00, flush};
    mod_after  = cur.chars_mod_four + n_all[1:0];

    // Padding brings the frame's character count up to a multiple of four,
    // but never beyond four characters for one byte.
    pads = 3'd0;
    if (frame_done) begin
      pads = {1'b0, 2'd0 - mod_after};
    end
    total = n_all + pads;
    if (total > 3'd4) begin
      total = 3'd4;
    end

    dchar[0] = jfb64e_pkg::sextet_char(sx0);
    dchar[1] = (n_data == 3'd2) ? jfb64e_pkg::sextet_char(sx1)
                                : jfb64e_pkg::sextet_char(flush_sx);
    dchar[2] = jfb64e_pkg::sextet_char(flush_sx);

    for (int i = 0; i < 4; i++) begin
      if (i < 3 && 3'(i) < n_all) begin
        burst.codes[i] = dchar[i];
      end else begin
        burst.codes[i] = jfb64e_pkg::PAD_CODE;
      end
    end
    burst.count     = total;
    burst.frame_end = frame_done;

    if (frame_done) begin
      nxt = '0;
    end else begin
      nxt.leftover_bits   = lo_bits;
      nxt.leftover_count  = lo_count;
      nxt.chars_mod_four  = mod_after;
      nxt.previous_was_ff = (data_byte == jfb64e_pkg::MARK_FF);
    end
  end

endmodule

// ----- rtl/core/jfb64e_serial.sv -----
// ----------------------------------------------------------------------------
// jfb64e_serial
// Holds one burst of characters and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jfb64e_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  jfb64e_pkg::burst_t  burst,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          char_code,
  output logic                frame_end,
  output logic                item_last
);

  logic [jfb64e_pkg::MAX_CHARS-1:0][jfb64e_pkg::CHAR_W-1:0] slots;
  logic [2:0] remain;
  logic       frame_flag;
  logic       take;

  assign out_valid = (remain != 3'd0);
  assign take      = out_valid && out_ready;
  assign item_last = (remain == 3'd1);
  assign frame_end = item_last && frame_flag;
  assign char_code = slots[0];
  // A new burst may enter as the last character of the current one leaves.
  assign can_load  = (remain == 3'd0) || (item_last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 3'd0;
    end else if (load) begin
      remain <= burst.count;
    end else if (take) begin
      remain <= remain - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots      <= burst.codes;
      frame_flag <= burst.frame_end;
    end else if (take) begin
      slots <= {jfb64e_pkg::PAD_CODE, slots[3:1]};
    end
  end

endmodule
